FILE: rtl/current_threshold_resistivity_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the current threshold resistivity unit
// Concurrent checks, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CURRENT_THRESHOLD_RESISTIVITY_UNIT_DEFINES_SVH
`define CURRENT_THRESHOLD_RESISTIVITY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CTR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CTR_ASSERT_NOW(label, ante, cons, msg)
`define CTR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/ctr_pkg.sv
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types and constants of the current threshold resistivity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ctr_pkg;

   localparam int DATA_W     = 32;
   localparam int ROOT_STEPS = 32;   // one root bit per step
   localparam int DIV_STEPS  = 32;   // one quotient bit per step
   localparam int SQ_TERMS   = 3;    // x, y, z
   localparam int CNT_W      = $clog2(ROOT_STEPS);

   // 0.1 in Q16.16, rounded to nearest
   localparam logic [DATA_W-1:0] CLAMP_Q16 = 32'd6554;

   // register indexes
   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_GAIN      = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   typedef enum logic [1:0] {
      MODE_CONST   = 2'd0,
      MODE_CURRENT = 2'd1,
      MODE_DRIFT   = 2'd2
   } mode_type;

   typedef struct packed {
      logic       load;
      logic       sq_mul;
      logic       sq_acc;
      logic [1:0] sq_sel;
      logic       root_step;
      logic       div_init;
      logic       div_step;
      logic       cmp;
      logic       mul;
      logic       commit;
   } ctr_cmd_type;

   typedef struct packed {
      logic dens_zero;
      logic div_sat;
      logic out_free;
   } ctr_sts_type;

endpackage

`default_nettype wire

FILE: rtl/ctr_ctrl.sv
// ----------------------------------------------------------------------------
// ctr_ctrl
// Sequencer: steps the datapath through squares, root, divide and scale as the mode needs.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ctr_pkg::mode_type    mode,
   input  wire ctr_pkg::ctr_sts_type sts,
   output ctr_pkg::ctr_cmd_type      cmd
);
   import ctr_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SQ    = 8'b0000_0010,
      S_ROOT  = 8'b0000_0100,
      S_DINIT = 8'b0000_1000,
      S_DIV   = 8'b0001_0000,
      S_CMP   = 8'b0010_0000,
      S_MUL   = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               if (mode == MODE_CURRENT || mode == MODE_DRIFT) begin
                  state_in = S_SQ;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SQ: begin
            cmd.sq_mul = (cnt_ff != CNT_W'(SQ_TERMS));
            cmd.sq_acc = (cnt_ff != '0);
            cmd.sq_sel = cnt_ff[1:0];
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SQ_TERMS)) begin
               cnt_in = '0;
               // drift with zero density skips straight to the clamp
               if (mode == MODE_DRIFT && sts.dens_zero) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = (mode == MODE_DRIFT) ? S_DINIT : S_CMP;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = sts.div_sat ? S_CMP : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ctr_dpath.sv
// ----------------------------------------------------------------------------
// ctr_dpath
// Datapath: shared multiplier, bit-serial root and divider, peak and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctr_pkg::ctr_cmd_type cmd,
   output ctr_pkg::ctr_sts_type      sts,
   input  wire ctr_pkg::mode_type    mode,
   input  wire logic [31:0]          gain,
   input  wire logic [31:0]          threshold,
   input  wire logic signed [31:0]   current_x,
   input  wire logic signed [31:0]   current_y,
   input  wire logic signed [31:0]   current_z,
   input  wire logic [31:0]          density,
   input  wire logic                 clear_peak,
   output logic [31:0]               resistivity,
   output logic [31:0]               peak_resistivity,
   output logic                      zero_density,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready
);
   import ctr_pkg::*;

   logic [DATA_W-1:0]   absx_ff, absx_in, absy_ff, absy_in, absz_ff, absz_in;
   logic [DATA_W-1:0]   dens_ff, dens_in;
   logic                clear_ff, clear_in;
   logic [2*DATA_W-1:0] prod_ff, prod_in;
   logic [2*DATA_W-1:0] rad_ff, rad_in;
   logic [DATA_W+1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   root_ff, root_in;
   logic                sat_ff, sat_in;
   logic [DATA_W-1:0]   drem_ff, drem_in;
   logic [DATA_W-1:0]   dsh_ff, dsh_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic                above_ff, above_in;
   logic [DATA_W-1:0]   excess_ff, excess_in;
   logic [DATA_W-1:0]   res_ff, res_in;
   logic [DATA_W-1:0]   peak_ff, peak_in;
   logic                zflag_ff, zflag_in;
   logic                valid_ff, valid_in;

   logic [DATA_W-1:0]   sq_op, mul_a, mul_b, tested, scaled, peak_base, res_new;
   logic [2*DATA_W-1:0] mul_p;
   logic [DATA_W+1:0]   rem_sh, trial;
   logic                root_ge, div_ge, drift_zero;
   logic [DATA_W:0]     dtop, ddiff;

   // shared 32x32 multiplier: squares, then excess times gain
   always_comb begin
      unique case (cmd.sq_sel)
         2'd0:    sq_op = absx_ff;
         2'd1:    sq_op = absy_ff;
         2'd2:    sq_op = absz_ff;
         default: sq_op = '0;
      endcase
   end

   assign mul_a = cmd.mul ? excess_ff : sq_op;
   assign mul_b = cmd.mul ? gain      : sq_op;
   assign mul_p = mul_a * mul_b;

   // root step: two radicand bits in, one root bit out
   assign rem_sh  = {rem_ff[DATA_W-1:0], rad_ff[2*DATA_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign root_ge = (rem_sh >= trial);

   // divide step: remainder stays below the density
   assign dtop   = {drem_ff, dsh_ff[DATA_W-1]};
   assign ddiff  = dtop - {1'b0, dens_ff};
   assign div_ge = (dtop >= {1'b0, dens_ff});

   assign tested = (mode == MODE_DRIFT) ? (sat_ff ? '1 : quo_ff) : root_ff;
   assign scaled = (prod_ff[2*DATA_W-1:16] > (2*DATA_W-16)'(CLAMP_Q16)) ?
                   CLAMP_Q16 : prod_ff[DATA_W+15:16];

   assign drift_zero = (mode == MODE_DRIFT) && (dens_ff == '0);
   assign peak_base  = clear_ff ? '0 : peak_ff;

   always_comb begin
      res_new = '0;
      unique case (mode)
         MODE_CONST:   res_new = gain;
         MODE_CURRENT: res_new = above_ff ? scaled : '0;
         MODE_DRIFT:   res_new = drift_zero ? CLAMP_Q16 : (above_ff ? scaled : '0);
         default:      res_new = '0;
      endcase
   end

   always_comb begin
      absx_in   = absx_ff;
      absy_in   = absy_ff;
      absz_in   = absz_ff;
      dens_in   = dens_ff;
      clear_in  = clear_ff;
      prod_in   = prod_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      sat_in    = sat_ff;
      drem_in   = drem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      above_in  = above_ff;
      excess_in = excess_ff;
      res_in    = res_ff;
      peak_in   = peak_ff;
      zflag_in  = zflag_ff;
      valid_in  = valid_ff & ~rsp_ready;

      if (cmd.load) begin
         absx_in  = current_x[DATA_W-1] ? (DATA_W'(0) - current_x) : current_x;
         absy_in  = current_y[DATA_W-1] ? (DATA_W'(0) - current_y) : current_y;
         absz_in  = current_z[DATA_W-1] ? (DATA_W'(0) - current_z) : current_z;
         dens_in  = density;
         clear_in = clear_peak;
         rad_in   = '0;
         rem_in   = '0;
         root_in  = '0;
      end
      if (cmd.sq_mul || cmd.mul) begin
         prod_in = mul_p;
      end
      if (cmd.sq_acc) begin
         rad_in = rad_ff + prod_ff;   // sum of squares fits 64 bits
      end
      if (cmd.root_step) begin
         rem_in  = root_ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[DATA_W-2:0], root_ge};
         rad_in  = {rad_ff[2*DATA_W-3:0], 2'b00};
      end
      if (cmd.div_init) begin
         // top 16 quotient bits are zero unless saturating
         sat_in  = ({16'd0, root_ff[DATA_W-1:16]} >= dens_ff);
         drem_in = {16'd0, root_ff[DATA_W-1:16]};
         dsh_in  = {root_ff[15:0], 16'd0};
         quo_in  = '0;
      end
      if (cmd.div_step) begin
         drem_in = div_ge ? ddiff[DATA_W-1:0] : dtop[DATA_W-1:0];
         dsh_in  = {dsh_ff[DATA_W-2:0], 1'b0};
         quo_in  = {quo_ff[DATA_W-2:0], div_ge};
      end
      if (cmd.cmp) begin
         above_in  = (tested > threshold);
         excess_in = tested - threshold;
      end
      if (cmd.commit) begin
         res_in   = res_new;
         zflag_in = drift_zero;
         valid_in = 1'b1;
         unique case (mode)
            MODE_CONST:   peak_in = gain;
            MODE_CURRENT,
            MODE_DRIFT:   peak_in = (res_new > peak_base) ? res_new : peak_base;
            default:      peak_in = peak_base;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      absx_ff   <= absx_in;
      absy_ff   <= absy_in;
      absz_ff   <= absz_in;
      dens_ff   <= dens_in;
      clear_ff  <= clear_in;
      prod_ff   <= prod_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      sat_ff    <= sat_in;
      drem_ff   <= drem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      above_ff  <= above_in;
      excess_ff <= excess_in;
      res_ff    <= res_in;
      zflag_ff  <= zflag_in;
      if (reset) begin
         peak_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         peak_ff  <= peak_in;
         valid_ff <= valid_in;
      end
   end

   assign sts.dens_zero = (dens_ff == '0);
   assign sts.div_sat   = ({16'd0, root_ff[DATA_W-1:16]} >= dens_ff);
   assign sts.out_free  = ~valid_ff | rsp_ready;

   assign resistivity      = res_ff;
   assign peak_resistivity = peak_ff;
   assign zero_density     = zflag_ff;
   assign rsp_valid        = valid_ff;

endmodule

`default_nettype wire

FILE: rtl/current_threshold_resistivity_unit.sv
// Constant and unused modes go straight to the result; current mode runs squares, root,
// compare and scale; drift mode adds the divide, skipped when the quotient saturates.
// One item at a time: a new beat is taken only once the previous result is registered.
// Cost is set by the 32-step bit-serial square root and the 32-step restoring divider.
// Synchronous active-high reset clears mode, gain, threshold, peak and the result valid.
// ----------------------------------------------------------------------------
// current_threshold_resistivity_unit
// Resistivity from current density magnitude or drift speed, with running peak.
// ----------------------------------------------------------------------------
`default_nettype none
`include "current_threshold_resistivity_unit_defines.svh"

module current_threshold_resistivity_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   // request beat
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // current_x, current_y, current_z, density
   input  wire logic         req_tuser,   // clear_peak
   // result beat
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // resistivity, peak_resistivity
   output logic              rsp_tuser,   // zero_density
   // register writes
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata
);
   import ctr_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [DATA_W-1:0] gain_ff, gain_in;
   logic [DATA_W-1:0] threshold_ff, threshold_in;

   ctr_cmd_type       cmd;
   ctr_sts_type       sts;
   logic [DATA_W-1:0] resistivity, peak_resistivity;
   logic              zero_density;

   // register file; writes to the spare index are dropped
   always_comb begin
      mode_in      = mode_ff;
      gain_in      = gain_ff;
      threshold_in = threshold_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE:      mode_in      = mode_type'(csr_wdata[1:0]);
            CSR_GAIN:      gain_in      = csr_wdata;
            CSR_THRESHOLD: threshold_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CONST;
         gain_ff      <= '0;
         threshold_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         threshold_ff <= threshold_in;
      end
   end

   // sequencer
   ctr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .mode      (mode_ff),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, peak register and result register
   ctr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .mode             (mode_ff),
      .gain             (gain_ff),
      .threshold        (threshold_ff),
      .current_x        ($signed(req_tdata[31:0])),
      .current_y        ($signed(req_tdata[63:32])),
      .current_z        ($signed(req_tdata[95:64])),
      .density          (req_tdata[127:96]),
      .clear_peak       (req_tuser),
      .resistivity      (resistivity),
      .peak_resistivity (peak_resistivity),
      .zero_density     (zero_density),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready)
   );

   assign rsp_tdata = {peak_resistivity, resistivity};
   assign rsp_tuser = zero_density;

   // zero density always comes with the clamp value
   `CTR_ASSERT_NOW(a_zero_dens_clamp, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == CLAMP_Q16, "zero density without clamp")
   // the reported peak never falls below the result it goes with
   `CTR_ASSERT_NOW(a_peak_covers, rsp_tvalid, rsp_tdata[63:32] >= rsp_tdata[31:0], "peak below result")
   // an accepted beat keeps the block busy for the next cycle
   `CTR_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready right after accept")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for current_threshold_resistivity_unit. Node beats go in
// on the request stream and resistivity beats come out on the result stream.
// An in-bench predictor models the magnitude, the drift quotient, the
// threshold clamp and the running peak, and every result beat is checked
// field by field. Register settings change only while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ctr_pkg::*;

   // mode code 3 has no enum member; the unit must still answer it
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;
   localparam logic [31:0] FULL_SCALE   = 32'hFFFF_FFFF;
   localparam int          GAP_MAX      = 17;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          RAND_PHASES  = 12;
   localparam int          PHASE_NODES  = 54;

   // one node as it travels on req_tdata / req_tuser
   typedef struct packed {
      logic [31:0] jx;
      logic [31:0] jy;
      logic [31:0] jz;
      logic [31:0] rho;
      logic        clr;
   } node_beat_type;

   // one result as it travels on rsp_tdata / rsp_tuser
   typedef struct packed {
      logic [31:0] eta;
      logic [31:0] eta_peak;
      logic        rho_zero;
   } eta_beat_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;     // current_x, current_y, current_z, density
   logic         req_tuser  = 1'b0;   // clear_peak
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;           // resistivity, peak_resistivity
   logic         rsp_tuser;           // zero_density
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_addr   = '0;
   logic [31:0]  csr_wdata  = '0;

   current_threshold_resistivity_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor's own copy of the registers and the peak
   logic [1:0]  cfg_mode  = '0;
   logic [31:0] cfg_gain  = '0;
   logic [31:0] cfg_thr   = '0;
   logic [31:0] peak_seen = '0;

   node_beat_type node_queue[$];   // nodes waiting to go out
   eta_beat_type  eta_queue[$];    // predicted results, oldest first
   int            n_fail = 0;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // |c|^2 of a signed Q16.16 component, Q32.32; -2^31 squares to 2^62
   function automatic logic [63:0] square_abs(input logic [31:0] c);
      logic [31:0] a;
      a = c[31] ? (~c + 32'd1) : c;
      return {32'd0, a} * {32'd0, a};
   endfunction

   // floor(sqrt(n)), built bit by bit from the top; clipped to 32 bits
   function automatic logic [31:0] root_floor(input logic [63:0] n);
      logic [32:0] root;
      logic [32:0] trial;
      logic [65:0] trial_sq;
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         trial    = root | (33'd1 << b);
         trial_sq = {33'd0, trial} * {33'd0, trial};
         if (trial_sq <= {2'b00, n})
            root = trial;
      end
      return root[32] ? FULL_SCALE : root[31:0];
   endfunction

   // gain * (mag - threshold), Q16.16, clamped to 0.1; zero at or below
   function automatic logic [31:0] excess_term(input logic [31:0] mag);
      logic [63:0] prod;
      if (mag <= cfg_thr)
         return 32'd0;
      prod = ({32'd0, mag - cfg_thr} * {32'd0, cfg_gain}) >> 16;
      return (prod > {32'd0, CLAMP_Q16}) ? CLAMP_Q16 : prod[31:0];
   endfunction

   // result of one node; moves the peak as a side effect
   function automatic eta_beat_type predict_node(input node_beat_type nb);
      eta_beat_type r;
      logic [63:0]  sum;
      logic [31:0]  mag;
      logic [47:0]  quot;
      r = '0;
      if (nb.clr)
         peak_seen = '0;
      case (cfg_mode)
         MODE_CONST: begin
            r.eta     = cfg_gain;
            peak_seen = cfg_gain;   // loaded, not compared
         end
         MODE_CURRENT, MODE_DRIFT: begin
            sum = square_abs(nb.jx) + square_abs(nb.jy) + square_abs(nb.jz);
            mag = root_floor(sum);
            if (cfg_mode == MODE_CURRENT) begin
               r.eta = excess_term(mag);
            end else if (nb.rho == '0) begin
               // no density: flag it and force the clamp
               r.rho_zero = 1'b1;
               r.eta      = CLAMP_Q16;
            end else begin
               quot  = {mag, 16'd0} / {16'd0, nb.rho};
               r.eta = excess_term((quot[47:32] != '0) ? FULL_SCALE : quot[31:0]);
            end
            if (r.eta > peak_seen)
               peak_seen = r.eta;
         end
         default: ;   // unused mode: zero result, peak untouched
      endcase
      r.eta_peak = peak_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // random helpers
   // ---------------------------------------------------------------------

   // gap before the next beat; now and then a calm run with no gaps at all
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0)
         calm_left = $urandom_range(8, 40);
      return $urandom_range(0, GAP_MAX);
   endfunction

   // signed component over many scales, with the extremes thrown in
   function automatic logic [31:0] rand_comp();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return raw[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $signed(raw) >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [31:0] rand_rho();
      case ($urandom_range(0, 11))
         0:       return 32'd0;
         1:       return FULL_SCALE;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // register value: the two ends often, otherwise any scale
   function automatic logic [31:0] rand_reg();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return FULL_SCALE;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic void queue_node(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] rho,
                                      input logic clr);
      node_beat_type nb;
      nb.jx  = x;
      nb.jy  = y;
      nb.jz  = z;
      nb.rho = rho;
      nb.clr = clr;
      node_queue.push_back(nb);
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   node_beat_type node_on_bus;
   int            send_gap  = 0;
   int            send_calm = 0;
   int            n_sent    = 0;
   logic          hold_for_drain = 1'b0;   // stop sending until all results are back

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            eta_queue.push_back(predict_node(node_on_bus));
            node_queue.delete(0);
            n_sent++;
            send_gap = draw_gap(send_calm);
            if (n_sent == 40 || $urandom_range(0, 99) == 0)
               hold_for_drain = 1'b1;
         end
         // bus may change only when idle or when the beat just went
         if (!req_tvalid || req_tready) begin
            if (hold_for_drain && eta_queue.size() == 0)
               hold_for_drain = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (hold_for_drain || node_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               node_on_bus = node_queue[0];
               req_tvalid <= 1'b1;
               req_tdata  <= {node_on_bus.rho, node_on_bus.jz, node_on_bus.jy,
                              node_on_bus.jx};
               req_tuser  <= node_on_bus.clr;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor
   // ---------------------------------------------------------------------
   eta_beat_type want;
   int           rcv_gap  = 0;
   int           rcv_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (eta_queue.size() == 0) begin
               $error("result beat with nothing expected: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               n_fail++;
            end else begin
               want = eta_queue.pop_front();
               if (rsp_tdata[31:0] !== want.eta) begin
                  $error("resistivity: expected %h, got %h", want.eta, rsp_tdata[31:0]);
                  n_fail++;
               end
               if (rsp_tdata[63:32] !== want.eta_peak) begin
                  $error("peak_resistivity: expected %h, got %h", want.eta_peak,
                         rsp_tdata[63:32]);
                  n_fail++;
               end
               if (rsp_tuser !== want.rho_zero) begin
                  $error("zero_density: expected %b, got %b", want.rho_zero, rsp_tuser);
                  n_fail++;
               end
            end
            rcv_gap = draw_gap(rcv_calm);
         end else if (!rsp_tvalid && rcv_gap == 0 && rcv_calm == 0
                      && $urandom_range(0, 15) == 0) begin
            // stall ahead of a result, so that it lands mid-stall
            rcv_gap = $urandom_range(1, GAP_MAX);
         end
         if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // register access, only with the unit idle
   // ---------------------------------------------------------------------
   task automatic settle();
      while (node_queue.size() != 0 || eta_queue.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_MODE:      cfg_mode = val[1:0];
         CSR_GAIN:      cfg_gain = val;
         CSR_THRESHOLD: cfg_thr  = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] mode, input logic [31:0] gain,
                            input logic [31:0] thr);
      settle();
      write_reg(CSR_MODE, {30'd0, mode});
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_THRESHOLD, thr);
   endtask

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      logic [1:0] mode_pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // current mode, threshold 1.0, gain 1.0
      configure(MODE_CURRENT, 32'h0001_0000, 32'h0001_0000);
      queue_node(32'd0, 32'd0, 32'd0, 32'd1, 1'b0);                 // zero vector
      queue_node(32'h0001_0000, 32'd0, 32'd0, 32'd1, 1'b0);         // exactly at threshold
      queue_node(32'd0, 32'hFFFE_FFFF, 32'd0, 32'd1, 1'b0);         // one lsb above
      queue_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, FULL_SCALE, 1'b0);
      queue_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b1);
      queue_node(32'h0001_8000, 32'hFFFE_8000, 32'd0, 32'd5, 1'b1); // clear, small result

      // drift mode: zero density, saturated quotient, widest density
      configure(MODE_DRIFT, 32'h0000_4000, 32'h0000_8000);
      queue_node(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1);
      queue_node(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_node(32'h8000_0000, 32'd0, 32'd0, 32'd1, 1'b0);
      queue_node(32'h0003_0000, 32'd0, 32'd0, FULL_SCALE, 1'b1);
      queue_node(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0);
      queue_node(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);

      // constant mode at full scale, with and without clear
      configure(MODE_CONST, FULL_SCALE, FULL_SCALE);
      queue_node(32'd1, 32'd2, 32'd3, 32'd0, 1'b0);
      queue_node(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd7, 1'b1);
      queue_node(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);

      // unused mode: zero result, peak kept unless cleared
      configure(MODE_UNUSED, 32'h0001_0000, 32'd0);
      queue_node(32'h0100_0000, 32'd0, 32'd0, 32'd1, 1'b0);
      queue_node(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_node(32'h0100_0000, 32'd0, 32'd0, 32'd1, 1'b1);

      // current mode with zero threshold and full gain: clamp from one lsb
      configure(MODE_CURRENT, FULL_SCALE, 32'd0);
      queue_node(32'd0, 32'd0, 32'd1, 32'd1, 1'b0);
      queue_node(32'd0, 32'd0, 32'd0, 32'd1, 1'b1);

      // drift with the threshold at full scale: saturated quotient stays off
      configure(MODE_DRIFT, FULL_SCALE, FULL_SCALE);
      queue_node(32'h8000_0000, 32'd0, 32'd0, 32'd1, 1'b1);
      queue_node(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 1'b0);
      queue_node(32'd5, 32'd0, 32'd0, 32'd0, 1'b0);

      // random phases, mostly the threshold modes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph % 4 == 3)
            mode_pick = $urandom_range(0, 3);
         else
            mode_pick = (ph % 2 == 1) ? MODE_DRIFT : MODE_CURRENT;
         configure(mode_pick, rand_reg(), rand_reg());
         repeat (PHASE_NODES)
            queue_node(rand_comp(), rand_comp(), rand_comp(), rand_rho(),
                       $urandom_range(0, 9) == 0);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);   // catch any stray result beat
      if (n_fail == 0 && eta_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
